[hdl/bxs_pkg.sv]
package bxs_pkg;

	localparam int AGENT_COUNT_DEF = 1024;
	localparam int IDX_W = 10;
	localparam logic [17:0] THRESH_RESET = 18'd66194;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_XCHG  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [9:0]  first_agent;
		logic [9:0]  second_agent;
		logic [15:0] alpha_one;
		logic [15:0] alpha_two;
		logic [31:0] holding_one;
		logic [31:0] holding_two;
	} in_item_t;

	typedef struct packed {
		logic        status;
		logic        traded;
		logic [31:0] amount_one;
		logic [31:0] amount_two;
		logic [31:0] read_holding_one;
		logic [31:0] read_holding_two;
		logic [63:0] volume_one;
		logic [63:0] volume_two;
		logic [31:0] trade_count;
	} out_item_t;

	// divider handshake
	typedef struct packed {
		logic         start;
		logic [111:0] num;
		logic [63:0]  den;
	} div_req_t;

	typedef enum logic [4:0] {
		S_IDLE, S_RDA, S_LATA, S_RDB, S_LATB,
		S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
		S_CMP, S_D1, S_D1W, S_D2, S_D2W, S_WB1, S_WB2, S_OUT
	} state_t;

endpackage

[hdl/bxs_ram.sv]
module bxs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

[hdl/bxs_div.sv]
// Restoring divider: floor(num / den), saturated to 32 bits, one bit a cycle.
module bxs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bxs_pkg::div_req_t req,
	output logic              done,
	output logic [31:0]       quot
);
	logic [111:0] num_q;
	logic [63:0]  den_q;
	logic [64:0]  rem_q;
	logic [31:0]  quo_q;
	logic         sat_q;
	logic         busy_q;
	logic [6:0]   cnt_q;
	logic [64:0]  shifted;
	logic         fits;

	assign shifted = {rem_q[63:0], num_q[111]};
	assign fits = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd111;
			end else if (busy_q) begin
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[110:0], 1'b0};
			rem_q <= fits ? shifted - {1'b0, den_q} : shifted;
			quo_q <= {quo_q[30:0], fits};
			if (fits && cnt_q >= 7'd32)
				sat_q <= 1'b1;
		end
	end

	assign quot = (den_q == '0) ? 32'd0 : (sat_q ? 32'hFFFF_FFFF : quo_q);
endmodule

[hdl/bilateral_exchange_step.sv]
// Bilateral exchange step: an agent table with trade evaluation.
// Channels: in (in_valid/in_ready, in_data), out (out_valid/out_ready, out_data)
// and a configuration write channel (cfg_valid/cfg_ready, cfg_data) carrying
// the trade threshold (Q2.16). Each input item yields exactly one output item.
// Items are handled one at a time through a sequencer around two single-port
// RAMs (alphas and holdings), each with a registered read.
// A trade runs two passes of a shared bit-serial divider, one per amount,
// followed by the write-back of both agents.
// Each rate product is built from two 48x24 partial products and the threshold
// product from three 32x18 ones, one a cycle.
// Reset clears accumulators and counter and loads the threshold with exp(0.01);
// the table holds nothing defined until written. When the receiver stalls, the
// result is held steady on the outputs and no new item is taken until it leaves.
module bilateral_exchange_step #(
	parameter int AGENT_COUNT = bxs_pkg::AGENT_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bxs_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bxs_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [17:0]         cfg_data
);
	localparam int AW = (AGENT_COUNT > 1) ? $clog2(AGENT_COUNT) : 1;

	// index reduction by reciprocal multiplication, exact for 10-bit indices
	localparam int RED_SH = bxs_pkg::IDX_W + $clog2(AGENT_COUNT);
	localparam logic [11:0] RED_MUL = 12'(((64'd1 << RED_SH) + 64'(AGENT_COUNT) - 64'd1)
		/ 64'(AGENT_COUNT));

	bxs_pkg::state_t state_q, state_d;
	bxs_pkg::in_item_t item_q;
	logic [17:0] thr_q;
	logic [63:0] vol1_q, vol2_q;
	logic [31:0] cnt_q;

	// agent fields: A = first party, B = second
	logic [15:0] a1a_q, a2a_q, a1b_q, a2b_q;
	logic [31:0] x1a_q, x2a_q, x1b_q, x2b_q;
	logic [47:0] t0_q, t1_q;          // first-level products
	logic [127:0] p_q, q_q;           // full rate products
	logic        fh_q;
	logic [127:0] mx_q, mn_q;
	logic [63:0] den_q;
	logic [31:0] amt1_q, amt2_q;
	logic        ok_q;

	// table ports
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]   alpha_wd, alpha_rd;
	logic [63:0]   hold_wd, hold_rd;

	bxs_ram #(.WIDTH(32), .DEPTH(AGENT_COUNT)) u_alpha (
		.clk, .we(ram_we), .addr(ram_addr), .wdata(alpha_wd), .rdata(alpha_rd));
	bxs_ram #(.WIDTH(64), .DEPTH(AGENT_COUNT)) u_hold (
		.clk, .we(ram_we), .addr(ram_addr), .wdata(hold_wd), .rdata(hold_rd));

	bxs_pkg::div_req_t dreq;
	logic        ddone;
	logic [31:0] dquot;
	bxs_div u_div (.clk, .arst_n, .req(dreq), .done(ddone), .quot(dquot));

	function automatic logic [AW-1:0] reduce_idx(input logic [9:0] idx);
		logic [21:0] prod;
		logic [9:0]  quo;
		logic [31:0] rem;
		prod = 22'(idx) * 22'(RED_MUL);
		quo  = 10'(prod >> RED_SH);
		rem  = 32'(idx) - 32'(quo) * 32'(AGENT_COUNT);
		return rem[AW-1:0];
	endfunction

	// reduce indices
	logic [AW-1:0] ia, ib;
	assign ia = reduce_idx(item_q.first_agent);
	assign ib = reduce_idx(item_q.second_agent);

	assign in_ready  = (state_q == bxs_pkg::S_IDLE);
	assign cfg_ready = 1'b1;

	// Saturating holding updates for the write-back
	logic [32:0] s_add1, l_add2;
	logic [31:0] sx1, sx2, lx1, lx2, nsx1, nsx2, nlx1, nlx2;
	assign sx1 = fh_q ? x1b_q : x1a_q;
	assign sx2 = fh_q ? x2b_q : x2a_q;
	assign lx1 = fh_q ? x1a_q : x1b_q;
	assign lx2 = fh_q ? x2a_q : x2b_q;
	assign s_add1 = {1'b0, sx1} + {1'b0, amt1_q};
	assign l_add2 = {1'b0, lx2} + {1'b0, amt2_q};
	assign nsx1 = s_add1[32] ? 32'hFFFF_FFFF : s_add1[31:0];
	assign nlx2 = l_add2[32] ? 32'hFFFF_FFFF : l_add2[31:0];
	assign nsx2 = (sx2 >= amt2_q) ? sx2 - amt2_q : 32'd0;
	assign nlx1 = (lx1 >= amt1_q) ? lx1 - amt1_q : 32'd0;

	// rate test: mx*65536 >= thr*mn, mn*thr built from three partial products
	logic [145:0] lhs, rhs;
	assign lhs = {2'b0, mx_q, 16'b0};
	assign rhs = {18'b0, p_q};  // p_q reused to hold thr*mn after S_M9

	// next state and table access
	always_comb begin
		state_d  = state_q;
		ram_we   = 1'b0;
		ram_addr = ia;
		alpha_wd = {item_q.alpha_two, item_q.alpha_one};
		hold_wd  = {item_q.holding_two, item_q.holding_one};
		dreq     = '0;
		unique case (state_q)
			bxs_pkg::S_IDLE:
				if (in_valid)
					state_d = bxs_pkg::S_RDA;
			bxs_pkg::S_RDA: begin
				unique case (bxs_pkg::op_t'(item_q.op))
					bxs_pkg::OP_WRITE: begin
						ram_we  = 1'b1;
						state_d = bxs_pkg::S_OUT;
					end
					bxs_pkg::OP_READ:  state_d = bxs_pkg::S_LATA;
					bxs_pkg::OP_XCHG:
						state_d = (ia == ib) ? bxs_pkg::S_OUT : bxs_pkg::S_LATA;
					default: state_d = bxs_pkg::S_OUT;
				endcase
			end
			bxs_pkg::S_LATA:
				state_d = (item_q.op == bxs_pkg::OP_READ) ? bxs_pkg::S_OUT : bxs_pkg::S_RDB;
			bxs_pkg::S_RDB: begin
				ram_addr = ib;
				state_d  = bxs_pkg::S_LATB;
			end
			bxs_pkg::S_LATB: state_d = bxs_pkg::S_M1;
			bxs_pkg::S_M1: state_d = bxs_pkg::S_M2;
			bxs_pkg::S_M2: state_d = bxs_pkg::S_M3;
			bxs_pkg::S_M3: state_d = bxs_pkg::S_M4;
			bxs_pkg::S_M4: state_d = bxs_pkg::S_M5;
			bxs_pkg::S_M5: state_d = bxs_pkg::S_M6;
			bxs_pkg::S_M6: state_d = bxs_pkg::S_M7;
			bxs_pkg::S_M7: state_d = bxs_pkg::S_M8;
			bxs_pkg::S_M8: state_d = bxs_pkg::S_M9;
			bxs_pkg::S_M9: state_d = bxs_pkg::S_CMP;
			bxs_pkg::S_CMP:
				state_d = (mx_q != '0 && lhs >= rhs) ? bxs_pkg::S_D1 : bxs_pkg::S_OUT;
			bxs_pkg::S_D1: begin
				dreq.start = 1'b1;
				dreq.num   = mx_q[127:16] - mn_q[127:16]
					- 112'(mx_q[15:0] < mn_q[15:0]);
				dreq.den   = den_q;
				state_d    = bxs_pkg::S_D1W;
			end
			bxs_pkg::S_D1W: if (ddone) state_d = bxs_pkg::S_D2;
			bxs_pkg::S_D2: begin
				dreq.start = 1'b1;
				dreq.num   = mx_q[127:16] - mn_q[127:16]
					- 112'(mx_q[15:0] < mn_q[15:0]);
				dreq.den   = den_q;
				state_d    = bxs_pkg::S_D2W;
			end
			bxs_pkg::S_D2W: if (ddone) state_d = bxs_pkg::S_WB1;
			bxs_pkg::S_WB1: begin
				// write the lower-rate agent
				ram_we   = 1'b1;
				ram_addr = fh_q ? ib : ia;
				alpha_wd = fh_q ? {a2b_q, a1b_q} : {a2a_q, a1a_q};
				hold_wd  = {nsx2, nsx1};
				state_d  = bxs_pkg::S_WB2;
			end
			bxs_pkg::S_WB2: begin
				ram_we   = 1'b1;
				ram_addr = fh_q ? ia : ib;
				alpha_wd = fh_q ? {a2a_q, a1a_q} : {a2b_q, a1b_q};
				hold_wd  = {nlx2, nlx1};
				state_d  = bxs_pkg::S_OUT;
			end
			bxs_pkg::S_OUT:
				if (out_ready)
					state_d = bxs_pkg::S_IDLE;
			default: state_d = bxs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bxs_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// threshold, accumulators and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= bxs_pkg::THRESH_RESET;
			vol1_q <= '0;
			vol2_q <= '0;
			cnt_q  <= '0;
			ok_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				thr_q <= cfg_data;
			if (state_q == bxs_pkg::S_IDLE)
				ok_q <= 1'b0;
			if (state_q == bxs_pkg::S_WB2) begin
				vol1_q <= vol1_q + 64'(amt1_q);
				vol2_q <= vol2_q + 64'(amt2_q);
				cnt_q  <= cnt_q + 32'd1;
				ok_q   <= 1'b1;
			end
		end
	end

	// datapath: one partial product per cycle, registered
	always_ff @(posedge clk) begin
		unique case (state_q)
			bxs_pkg::S_IDLE:
				if (in_valid)
					item_q <= in_data;
			bxs_pkg::S_LATA: begin
				{a2a_q, a1a_q} <= alpha_rd;
				{x2a_q, x1a_q} <= hold_rd;
			end
			bxs_pkg::S_LATB: begin
				{a2b_q, a1b_q} <= alpha_rd;
				{x2b_q, x1b_q} <= hold_rd;
			end
			bxs_pkg::S_M1: begin
				t0_q <= 48'(a2a_q) * 48'(x1a_q);
				t1_q <= 48'(a1b_q) * 48'(x2b_q);
			end
			bxs_pkg::S_M2: begin
				// P = t0*t1, split t1 into halves of 24 bits
				p_q <= 128'(t0_q * 72'(t1_q[23:0]));
			end
			bxs_pkg::S_M3: begin
				p_q <= p_q + (128'(t0_q * 72'(t1_q[47:24])) << 24);
				t0_q <= 48'(a1a_q) * 48'(x2a_q);
				t1_q <= 48'(a2b_q) * 48'(x1b_q);
			end
			bxs_pkg::S_M4: q_q <= 128'(t0_q * 72'(t1_q[23:0]));
			bxs_pkg::S_M5: q_q <= q_q + (128'(t0_q * 72'(t1_q[47:24])) << 24);
			bxs_pkg::S_M6: begin
				fh_q <= p_q > q_q;
				mx_q <= (p_q > q_q) ? p_q : q_q;
				mn_q <= (p_q > q_q) ? q_q : p_q;
			end
			bxs_pkg::S_M7: begin
				// thr*mn, one 32-bit slice of mn a cycle; mn never exceeds 96 bits
				p_q  <= 128'(mn_q[31:0] * 50'(thr_q));
				// first denominator: La1*Lx2 + Sa1*Sx2
				t0_q <= 48'(a1a_q) * 48'(x2a_q);
				t1_q <= 48'(a1b_q) * 48'(x2b_q);
			end
			bxs_pkg::S_M8: begin
				p_q   <= p_q + (128'(mn_q[63:32] * 50'(thr_q)) << 32);
				den_q <= 64'(t0_q) + 64'(t1_q);
			end
			bxs_pkg::S_M9:
				p_q <= p_q + (128'(mn_q[95:64] * 50'(thr_q)) << 64);
			bxs_pkg::S_D1W:
				if (ddone) begin
					amt1_q <= dquot;
					den_q  <= 64'(48'(a2a_q) * 48'(x1a_q))
						+ 64'(48'(a2b_q) * 48'(x1b_q));
				end
			bxs_pkg::S_D2W:
				if (ddone)
					amt2_q <= dquot;
			default: ;
		endcase
	end

	// output: decoded from registered state, held until taken
	always_comb begin
		out_data = '0;
		out_data.status = (item_q.op == bxs_pkg::OP_XCHG) && (ia == ib);
		out_data.traded = ok_q;
		if (ok_q) begin
			out_data.amount_one = amt1_q;
			out_data.amount_two = amt2_q;
		end
		if (item_q.op == bxs_pkg::OP_READ) begin
			out_data.read_holding_one = x1a_q;
			out_data.read_holding_two = x2a_q;
		end
		out_data.volume_one  = vol1_q;
		out_data.volume_two  = vol2_q;
		out_data.trade_count = cnt_q;
	end
	assign out_valid = (state_q == bxs_pkg::S_OUT);
endmodule

[hdl/bxs_checker.sv]
module bxs_assert (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input bxs_pkg::out_item_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken straight after the first");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.traded |->
			out_data.status == 1'b0)
		else $error("trade with same agent twice");

	a_no_trade_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.traded |->
			out_data.amount_one == 32'd0 && out_data.amount_two == 32'd0)
		else $error("amount without trade");
endmodule

bind bilateral_exchange_step bxs_assert u_bxs_assert (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data);

[bench/bxs_checker.sv]
module bxs_checker
	import bxs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_item_t   out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [17:0] cfg_data,
	output int          fail_count,
	output int          results_seen,
	output int          trades_done
);
	timeunit 1ns;
	timeprecision 1ps;

	// own copy of the agent table and the running totals
	bit [31:0] alpha_tbl [1024];
	bit [63:0] hold_tbl [1024];
	bit [63:0] vol_one, vol_two;
	bit [31:0] xchg_count;
	bit [17:0] threshold = THRESH_RESET;

	out_item_t awaited [$];

	// floor(num / den / 65536), clipped to 32 bits
	function automatic logic [31:0] share(input logic [127:0] num, input logic [63:0] den);
		logic [127:0] quo;
		if (den == 0)
			return '0;
		quo = (num >> 16) / {64'd0, den};
		return (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
	endfunction

	function automatic out_item_t settle_item(input in_item_t it);
		out_item_t r;
		logic [9:0] ia, ib, li, si;
		logic [127:0] p, q, mx, mn, num;
		logic [15:0] la1, la2, sa1, sa2;
		logic [31:0] lx1, lx2, sx1, sx2, amt1, amt2;
		logic [32:0] sum;
		r = '0;
		ia = it.first_agent;
		ib = it.second_agent;
		case (op_t'(it.op))
			OP_WRITE: begin
				alpha_tbl[ia] = {it.alpha_two, it.alpha_one};
				hold_tbl[ia] = {it.holding_two, it.holding_one};
			end
			OP_READ: begin
				r.read_holding_one = hold_tbl[ia][31:0];
				r.read_holding_two = hold_tbl[ia][63:32];
			end
			OP_XCHG: begin
				if (ia == ib) begin
					r.status = 1'b1;
				end else begin
					p = 128'(alpha_tbl[ia][31:16]) * 128'(hold_tbl[ia][31:0])
						* 128'(alpha_tbl[ib][15:0]) * 128'(hold_tbl[ib][63:32]);
					q = 128'(alpha_tbl[ia][15:0]) * 128'(hold_tbl[ia][63:32])
						* 128'(alpha_tbl[ib][31:16]) * 128'(hold_tbl[ib][31:0]);
					li = (p > q) ? ia : ib;
					si = (p > q) ? ib : ia;
					mx = (p > q) ? p : q;
					mn = (p > q) ? q : p;
					if (mx != 0 && (mx << 16) >= mn * 128'(threshold)) begin
						la1 = alpha_tbl[li][15:0];
						la2 = alpha_tbl[li][31:16];
						sa1 = alpha_tbl[si][15:0];
						sa2 = alpha_tbl[si][31:16];
						lx1 = hold_tbl[li][31:0];
						lx2 = hold_tbl[li][63:32];
						sx1 = hold_tbl[si][31:0];
						sx2 = hold_tbl[si][63:32];
						num = mx - mn;
						amt1 = share(num, 64'(la1) * 64'(lx2) + 64'(sa1) * 64'(sx2));
						amt2 = share(num, 64'(la2) * 64'(lx1) + 64'(sa2) * 64'(sx1));
						sum = {1'b0, sx1} + {1'b0, amt1};
						sx1 = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
						sx2 = (sx2 >= amt2) ? sx2 - amt2 : '0;
						lx1 = (lx1 >= amt1) ? lx1 - amt1 : '0;
						sum = {1'b0, lx2} + {1'b0, amt2};
						lx2 = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
						hold_tbl[si] = {sx2, sx1};
						hold_tbl[li] = {lx2, lx1};
						vol_one = vol_one + 64'(amt1);
						vol_two = vol_two + 64'(amt2);
						xchg_count = xchg_count + 1;
						r.traded = 1'b1;
						r.amount_one = amt1;
						r.amount_two = amt2;
					end
				end
			end
			default: ;
		endcase
		r.volume_one = vol_one;
		r.volume_two = vol_two;
		r.trade_count = xchg_count;
		return r;
	endfunction

	task automatic field_check(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%t result %0d: %s expected %h, got %h", $realtime, results_seen,
					name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			threshold <= cfg_data;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			awaited.push_back(settle_item(in_data));
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%t result with nothing awaited", $realtime);
			end else begin
				want = awaited.pop_front();
				field_check("status", 64'(want.status), 64'(out_data.status));
				field_check("traded", 64'(want.traded), 64'(out_data.traded));
				field_check("amount_one", 64'(want.amount_one), 64'(out_data.amount_one));
				field_check("amount_two", 64'(want.amount_two), 64'(out_data.amount_two));
				field_check("read_holding_one", 64'(want.read_holding_one),
					64'(out_data.read_holding_one));
				field_check("read_holding_two", 64'(want.read_holding_two),
					64'(out_data.read_holding_two));
				field_check("volume_one", want.volume_one, out_data.volume_one);
				field_check("volume_two", want.volume_two, out_data.volume_two);
				field_check("trade_count", 64'(want.trade_count), 64'(out_data.trade_count));
				if (want.traded)
					trades_done++;
			end
			results_seen++;
		end
	end

endmodule

[bench/testbench.sv]
module testbench;
	import bxs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// quiet time after each drain, with margin beyond the slowest trade in the block
	localparam int SETTLE_CYCLES = 400;
	localparam int PHASE_ITEMS = 330;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [17:0] cfg_data;

	int fail_count, results_seen, trades_done;
	int items_sent = 0;
	int directed_items = 0;

	// which agents hold defined data, and a small crowd that is written often
	bit written [1024];
	int known_agents [$];
	int crowd [$];

	bilateral_exchange_step uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	bxs_checker watcher (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.results_seen (results_seen),
		.trades_done  (trades_done)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("[bilateral_exchange_step] ERROR");
		$finish;
	end

	// receiver: pick a stall pattern every so often, one of them never stalling
	initial begin
		int mode;
		int span;
		out_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 600);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	function automatic in_item_t make_item(input op_t op, input int a, input int b,
		input logic [15:0] al1, input logic [15:0] al2,
		input logic [31:0] h1, input logic [31:0] h2);
		in_item_t it;
		it.op = op;
		it.first_agent = a[9:0];
		it.second_agent = b[9:0];
		it.alpha_one = al1;
		it.alpha_two = al2;
		it.holding_one = h1;
		it.holding_two = h2;
		return it;
	endfunction

	function automatic logic [31:0] pick_holding();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1 << 20);
			1: return $urandom_range(1 << 16, 1 << 24);
			2: return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_alpha();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 255));
			1: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'd0;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic int pick_known();
		return known_agents[$urandom_range(0, known_agents.size() - 1)];
	endfunction

	// mostly well-formed traffic among defined agents, with some noise
	function automatic in_item_t random_item();
		int roll;
		int a, b;
		roll = $urandom_range(0, 99);
		a = pick_known();
		b = pick_known();
		if (roll < 22) begin
			a = ($urandom_range(0, 9) < 7) ? crowd[$urandom_range(0, crowd.size() - 1)]
				: $urandom_range(0, 1023);
			return make_item(OP_WRITE, a, $urandom_range(0, 1023), pick_alpha(),
				pick_alpha(), pick_holding(), pick_holding());
		end
		if (roll < 36)
			return make_item(OP_READ, a, $urandom_range(0, 1023), 16'($urandom),
				16'($urandom), $urandom, $urandom);
		if (roll < 40)
			return make_item(OP_XCHG, a, a, 16'($urandom), 16'($urandom), $urandom,
				$urandom);
		if (roll < 44)
			return make_item(OP_NOP, $urandom_range(0, 1023), $urandom_range(0, 1023),
				16'($urandom), 16'($urandom), $urandom, $urandom);
		// redraw once so that most exchanges name two parties
		if (a == b)
			b = pick_known();
		return make_item(OP_XCHG, a, b, 16'($urandom), 16'($urandom), $urandom, $urandom);
	endfunction

	// hold the item until the block takes it; valid stays high for a follower
	task automatic offer(input in_item_t it);
		if (it.op == OP_WRITE && !written[it.first_agent]) begin
			written[it.first_agent] = 1'b1;
			known_agents.push_back(int'(it.first_agent));
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// drop valid and wait until every result is back, then let the block go quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (results_seen != items_sent)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [17:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// random traffic in bursts, with gaps of random length between them
	task automatic random_phase(input int count);
		int left;
		int burst;
		int gap;
		left = count;
		while (left > 0) begin
			burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
			if (burst > left)
				burst = left;
			repeat (burst)
				offer(random_item());
			left -= burst;
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// now and then, hold off until the block has answered everything
			if ($urandom_range(0, 39) == 0)
				drain();
		end
	endtask

	initial begin
		logic [17:0] spread;
		int total_fail;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		repeat (24)
			crowd.push_back($urandom_range(0, 1023));

		// directed part, under the threshold left by reset
		offer(make_item(OP_WRITE, 0, 0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		offer(make_item(OP_WRITE, 1023, 1023, 16'h0, 16'h0, 32'h0, 32'h0));
		offer(make_item(OP_WRITE, 1, 0, 16'h8000, 16'h4000, 32'h1_0000, 32'h2_0000));
		offer(make_item(OP_WRITE, 2, 0, 16'h4000, 16'h8000, 32'h2_0000, 32'h1_0000));
		// agent 3 copies agent 1, so their rates tie
		offer(make_item(OP_WRITE, 3, 0, 16'h8000, 16'h4000, 32'h1_0000, 32'h2_0000));
		offer(make_item(OP_READ, 0, 1023, '0, '0, '0, '0));
		offer(make_item(OP_READ, 1023, 0, '0, '0, '0, '0));
		// same agent twice: refused
		offer(make_item(OP_XCHG, 1, 1, '0, '0, '0, '0));
		// equal rates: no trade
		offer(make_item(OP_XCHG, 1, 3, '0, '0, '0, '0));
		// all-zero agent: no rate at all
		offer(make_item(OP_XCHG, 0, 1023, '0, '0, '0, '0));
		offer(make_item(OP_XCHG, 1, 2, '0, '0, '0, '0));
		offer(make_item(OP_XCHG, 2, 1, '0, '0, '0, '0));
		// lopsided agents push amounts and holdings to their limits
		offer(make_item(OP_WRITE, 4, 0, 16'h0001, 16'hFFFF, 32'hFFFF_FFFF, 32'h1));
		offer(make_item(OP_WRITE, 5, 0, 16'hFFFF, 16'h0001, 32'h1, 32'hFFFF_FFFF));
		offer(make_item(OP_XCHG, 4, 5, '0, '0, '0, '0));
		offer(make_item(OP_XCHG, 0, 4, '0, '0, '0, '0));
		offer(make_item(OP_XCHG, 5, 0, '0, '0, '0, '0));
		offer(make_item(OP_READ, 4, 0, '0, '0, '0, '0));
		offer(make_item(OP_READ, 5, 0, '0, '0, '0, '0));
		offer(make_item(OP_NOP, 1023, 1023, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		offer(make_item(OP_READ, 1, 2, '0, '0, '0, '0));
		offer(make_item(OP_READ, 2, 1, '0, '0, '0, '0));
		directed_items = items_sent;

		// random phases, each under its own threshold, the extremes included
		spread = 18'($urandom_range(65536, 262143));
		set_threshold(18'd65536);
		random_phase(PHASE_ITEMS);
		set_threshold(18'd262143);
		random_phase(PHASE_ITEMS);
		set_threshold(spread);
		random_phase(PHASE_ITEMS);
		set_threshold(18'd70000);
		random_phase(PHASE_ITEMS);
		set_threshold(THRESH_RESET);
		random_phase(PHASE_ITEMS);

		drain();
		total_fail = fail_count + (items_sent - results_seen);
		$display("Sent %0d items (%0d directed) over five thresholds from 1.0 to just under 4.0;",
			items_sent, directed_items);
		$display("%0d exchanges went through among %0d defined agents.", trades_done,
			known_agents.size());
		if (total_fail == 0) begin
			$display("[bilateral_exchange_step] OK");
		end else begin
			$display("[bilateral_exchange_step] ERROR");
		end
		$finish;
	end

endmodule
